FILE: rtl/pixel_replicate_upscaler_unit_assert.svh
// Assertion macros used by the back part of the pixel replicate upscaler.
`ifndef PIXEL_REPLICATE_UPSCALER_UNIT_ASSERT_SVH
`define PIXEL_REPLICATE_UPSCALER_UNIT_ASSERT_SVH

// Checks cons in the same cycle whenever ante holds.
`define PRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks cons in the cycle after ante holds.
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pru_pkg.sv
// Types and constants of the pixel replicate upscaler.
package pru_pkg;

  localparam int COLOR_W     = 16;
  localparam int COORD_W     = 13;
  localparam int DIM_W       = 11;
  localparam int FACTOR_W    = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_FACTOR = 8;

  localparam logic [DIM_W-1:0]    RESET_WIDTH  = DIM_W'(1);
  localparam logic [DIM_W-1:0]    RESET_HEIGHT = DIM_W'(1);
  localparam logic [FACTOR_W-1:0] RESET_FACTOR = FACTOR_W'(2);
  localparam logic                RESET_MASK   = 1'b0;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH    = 2'd0,
    REG_SRC_HEIGHT   = 2'd1,
    REG_SCALE_FACTOR = 2'd2,
    REG_MASK_ENABLE  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               pixel_mask;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [COLOR_W-1:0] out_color;
    logic               out_mask;
    logic               last_of_block;
  } pixel_out_t;

  typedef struct packed {
    logic [DIM_W-1:0]    src_width;
    logic [DIM_W-1:0]    src_height;
    logic [FACTOR_W-1:0] scale_factor;
    logic                mask_enable;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0]  base_x;
    logic [COORD_W-1:0]  base_y;
    logic [COLOR_W-1:0]  color;
    logic                mask;
    logic [FACTOR_W-1:0] factor;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

FILE: rtl/pru_queue.sv
// Short command queue between the front and back parts of the upscaler.
module pru_queue
  import pru_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

FILE: rtl/pru_front.sv
// Front part: accepts source pixels, tracks the source position, builds commands.
module pru_front
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      src_valid,
  output logic      src_ready,
  input  pixel_in_t src_pixel,
  input  q_status_t q_status,
  output logic      push,
  output cmd_t      push_cmd
);

  localparam int POS_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [POS_W-1:0]          col;
  logic [POS_W-1:0]          row;
  logic [POS_W-1:0]          col_next;
  logic [POS_W-1:0]          row_next;
  logic [POS_W:0]            col_inc;
  logic [POS_W:0]            row_inc;
  logic [DIM_W-1:0]          width_eff;
  logic [DIM_W-1:0]          height_eff;
  logic [FACTOR_W-1:0]       factor_eff;
  logic [POS_W+FACTOR_W-1:0] prod_x;
  logic [POS_W+FACTOR_W-1:0] prod_y;
  logic                      accept;

  assign src_ready = !q_status.full;
  assign accept    = src_valid && src_ready;

  always_comb begin
    if (cfg.src_width == '0) begin
      width_eff = DIM_W'(1);
    end else if (32'(cfg.src_width) > 32'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = cfg.src_width;
    end
    if (cfg.src_height == '0) begin
      height_eff = DIM_W'(1);
    end else if (32'(cfg.src_height) > 32'(MAX_WIDTH)) begin
      height_eff = DIM_W'(MAX_WIDTH);
    end else begin
      height_eff = cfg.src_height;
    end
    if (32'(cfg.scale_factor) > 32'(MAX_FACTOR)) begin
      factor_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      factor_eff = cfg.scale_factor;
    end

    prod_x = col * factor_eff;
    prod_y = row * factor_eff;

    push_cmd.base_x = COORD_W'(prod_x);
    push_cmd.base_y = COORD_W'(prod_y);
    push_cmd.color  = src_pixel.pixel_color;
    push_cmd.mask   = cfg.mask_enable && src_pixel.pixel_mask;
    push_cmd.factor = factor_eff;

    // A factor of zero produces no replicas, but the position still moves on.
    push = accept && (factor_eff != '0);

    col_inc  = {1'b0, col} + 1'b1;
    row_inc  = {1'b0, row} + 1'b1;
    col_next = POS_W'(col_inc);
    row_next = row;
    if (32'(col_inc) >= 32'(width_eff)) begin
      col_next = '0;
      if (32'(row_inc) >= 32'(height_eff)) begin
        row_next = '0;
      end else begin
        row_next = POS_W'(row_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

FILE: rtl/pru_back.sv
// Back part: walks the replica block of each command and drives the result register.
`include "pixel_replicate_upscaler_unit_assert.svh"

module pru_back
  import pru_pkg::*;
#(
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  q_status_t  q_status,
  output logic       pop,
  output logic       dst_valid,
  input  logic       dst_ready,
  output pixel_out_t dst_pixel
);

  localparam int CNT_W = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;

  logic [CNT_W-1:0] col_cnt;
  logic [CNT_W-1:0] row_cnt;
  logic             emit;
  logic             last_col;
  logic             last_row;

  always_comb begin
    emit     = !q_status.empty && (!dst_valid || dst_ready);
    last_col = (FACTOR_W'(col_cnt) == FACTOR_W'(head.factor - 1'b1));
    last_row = (FACTOR_W'(row_cnt) == FACTOR_W'(head.factor - 1'b1));
    pop      = emit && last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      dst_valid <= 1'b0;
    end else begin
      if (emit) begin
        dst_valid <= 1'b1;
        col_cnt   <= last_col ? '0 : CNT_W'(col_cnt + 1'b1);
        if (last_col) begin
          row_cnt <= last_row ? '0 : CNT_W'(row_cnt + 1'b1);
        end
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dst_pixel.dest_x        <= COORD_W'(head.base_x + COORD_W'(col_cnt));
      dst_pixel.dest_y        <= COORD_W'(head.base_y + COORD_W'(row_cnt));
      dst_pixel.out_color     <= head.color;
      dst_pixel.out_mask      <= head.mask;
      dst_pixel.last_of_block <= last_col && last_row;
    end
  end

  `PRU_ASSERT_NOW(a_col_in_range, !q_status.empty, FACTOR_W'(col_cnt) < head.factor,
                  "column count past factor")
  `PRU_ASSERT_NOW(a_row_in_range, !q_status.empty, FACTOR_W'(row_cnt) < head.factor,
                  "row count past factor")
  `PRU_ASSERT_NEXT(a_pop_marks_last, pop, dst_valid && dst_pixel.last_of_block,
                   "pop without last item")
  `PRU_ASSERT_NEXT(a_counters_restart, pop, col_cnt == '0 && row_cnt == '0,
                   "counters not restarted")

endmodule

FILE: rtl/pixel_replicate_upscaler_unit.sv
// Top level of the pixel replicate upscaler: register port, front, queue and back.
//
//   channel   | signals                               | item
//   ----------+---------------------------------------+-----------------------------
//   source    | src_valid, src_ready, src_pixel       | one source pixel
//   result    | dst_valid, dst_ready, dst_pixel       | one destination pixel
//   registers | psel, penable, pwrite, paddr, pwdata  | one register write or read
//
// The back part sends one result per cycle while dst_ready allows, so a source pixel gives factor squared
// results, four at factor two; the front accepts one pixel per cycle while the two-entry queue has room.
// Results leave from a register, and the back keeps working while the queue holds commands.
// Reset clears the source position, the queue, the counters and the registers to defaults.
// A stall on the result side fills the queue and then holds src_ready low.
module pixel_replicate_upscaler_unit
  import pru_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  pixel_in_t         src_pixel,
  output logic              dst_valid,
  input  logic              dst_ready,
  output pixel_out_t        dst_pixel,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  reg_idx_t  reg_idx;
  logic      wr_en;
  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_status;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_width    <= RESET_WIDTH;
      cfg.src_height   <= RESET_HEIGHT;
      cfg.scale_factor <= RESET_FACTOR;
      cfg.mask_enable  <= RESET_MASK;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_WIDTH:    cfg.src_width    <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT:   cfg.src_height   <= pwdata[DIM_W-1:0];
        REG_SCALE_FACTOR: cfg.scale_factor <= pwdata[FACTOR_W-1:0];
        REG_MASK_ENABLE:  cfg.mask_enable  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_WIDTH:    prdata = DATA_W'(cfg.src_width);
      REG_SRC_HEIGHT:   prdata = DATA_W'(cfg.src_height);
      REG_SCALE_FACTOR: prdata = DATA_W'(cfg.scale_factor);
      REG_MASK_ENABLE:  prdata = DATA_W'(cfg.mask_enable);
      default:          prdata = '0;
    endcase
  end

  pru_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_pixel (src_pixel),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  pru_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  pru_back #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_pixel (dst_pixel)
  );

endmodule

FILE: tb/pru_replica_checker.sv
// Checker that predicts and compares the replicated pixels of the upscaler.
`timescale 1ns / 100ps

module pru_replica_checker
  import pru_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  input  logic              src_ready,
  input  pixel_in_t         src_pixel,
  input  logic              dst_valid,
  input  logic              dst_ready,
  input  pixel_out_t        dst_pixel,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                mismatches,
  output int                outstanding,
  output int                compared
);

  cfg_t       cfg;
  logic [9:0] col_pos;
  logic [9:0] row_pos;
  pixel_out_t replicas_due[$];

  function automatic int clamp_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return int'(d);
  endfunction

  function automatic void replicate_pixel(pixel_in_t p);
    int f;
    int w;
    int h;
    pixel_out_t r;
    f = (cfg.scale_factor > DEF_MAX_FACTOR) ? DEF_MAX_FACTOR : int'(cfg.scale_factor);
    w = clamp_dim(cfg.src_width);
    h = clamp_dim(cfg.src_height);
    for (int j = 0; j < f; j++) begin
      for (int i = 0; i < f; i++) begin
        r.dest_x        = COORD_W'(int'(col_pos) * f + i);
        r.dest_y        = COORD_W'(int'(row_pos) * f + j);
        r.out_color     = p.pixel_color;
        r.out_mask      = cfg.mask_enable ? p.pixel_mask : 1'b0;
        r.last_of_block = (j == f - 1) && (i == f - 1);
        replicas_due.push_back(r);
      end
    end
    if (int'(col_pos) + 1 >= w) begin
      col_pos = '0;
      if (int'(row_pos) + 1 >= h) begin
        row_pos = '0;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic void compare_replica(pixel_out_t got);
    pixel_out_t want;
    if (replicas_due.size() == 0) begin
      $error("unexpected replica: dest_x %0d dest_y %0d color %0h",
             got.dest_x, got.dest_y, got.out_color);
      mismatches++;
      return;
    end
    want = replicas_due.pop_front();
    compared++;
    if (got.dest_x !== want.dest_x) begin
      $error("dest_x: expected %0d, actual %0d", want.dest_x, got.dest_x);
      mismatches++;
    end
    if (got.dest_y !== want.dest_y) begin
      $error("dest_y: expected %0d, actual %0d", want.dest_y, got.dest_y);
      mismatches++;
    end
    if (got.out_color !== want.out_color) begin
      $error("out_color: expected %0h, actual %0h", want.out_color, got.out_color);
      mismatches++;
    end
    if (got.out_mask !== want.out_mask) begin
      $error("out_mask: expected %0b, actual %0b", want.out_mask, got.out_mask);
      mismatches++;
    end
    if (got.last_of_block !== want.last_of_block) begin
      $error("last_of_block: expected %0b, actual %0b", want.last_of_block,
             got.last_of_block);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg = '{src_width: RESET_WIDTH, src_height: RESET_HEIGHT,
              scale_factor: RESET_FACTOR, mask_enable: RESET_MASK};
      col_pos = '0;
      row_pos = '0;
      replicas_due.delete();
      mismatches = 0;
      compared = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
          REG_SRC_WIDTH: begin
            cfg.src_width = pwdata[DIM_W-1:0];
          end
          REG_SRC_HEIGHT: begin
            cfg.src_height = pwdata[DIM_W-1:0];
          end
          REG_SCALE_FACTOR: begin
            cfg.scale_factor = pwdata[FACTOR_W-1:0];
          end
          REG_MASK_ENABLE: begin
            cfg.mask_enable = pwdata[0];
          end
          default: begin
          end
        endcase
      end
      if (dst_valid && dst_ready) begin
        compare_replica(dst_pixel);
      end
      if (src_valid && src_ready) begin
        replicate_pixel(src_pixel);
      end
    end
    outstanding <= replicas_due.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the pixel replicate upscaler: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb;
  import pru_pkg::*;

  localparam int PIXEL_TARGET    = 330;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 20;
  localparam int HOLD_OFF_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              src_valid;
  logic              src_ready;
  pixel_in_t         src_pixel;
  logic              dst_valid;
  logic              dst_ready;
  pixel_out_t        dst_pixel;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int compared;
  int pixels_sent;
  int settings_used;
  int cycles;
  int tx_gap_pct;
  int rx_gap_pct;
  bit calm;
  bit hold_off_req;

  pixel_replicate_upscaler_unit dut (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_pixel(src_pixel),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_pixel(dst_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  pru_replica_checker chk (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src_pixel(src_pixel),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst_pixel(dst_pixel),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatches(mismatches), .outstanding(outstanding), .compared(compared)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    dst_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        dst_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        dst_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < rx_gap_pct) begin
        dst_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        dst_ready <= 1'b1;
      end else begin
        dst_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(int unsigned w, h, f, m);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_SCALE_FACTOR, f);
    write_reg(REG_MASK_ENABLE, m);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pixel(logic [COLOR_W-1:0] color, logic mask);
    if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_pixel <= '{pixel_color: color, pixel_mask: mask};
    do @(posedge clk); while (!src_ready);
    pixels_sent++;
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic int unsigned pick_dim();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(0, 2047);
  endfunction

  task automatic random_phase(int count, bit hold_off);
    int unsigned f;
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (hold_off) begin
      f = 2;
    end else if (roll < 6) begin
      f = $urandom_range(1, 3);
    end else if (roll < 9) begin
      f = $urandom_range(4, 8);
    end else begin
      f = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
    end
    configure(pick_dim(), pick_dim(), f, $urandom_range(0, 1));
    tx_gap_pct = hold_off ? 0 : $urandom_range(0, 3) * 10;
    rx_gap_pct = $urandom_range(0, 3) * 10;
    if (hold_off) begin
      hold_off_req = 1'b1;
    end
    repeat (count) begin
      send_pixel(COLOR_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
    end
    drain();
  endtask

  initial begin
    int phase_no;
    rst       <= 1'b1;
    src_valid <= 1'b0;
    src_pixel <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset defaults: one pixel wide and high, factor two, mask disabled.
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b1);
    drain();

    configure(3, 2, 1, 1);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h8000, 1'b1);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hF800, 1'b1);
    send_pixel(16'h07E0, 1'b0);
    send_pixel(16'h001F, 1'b1);
    drain();

    // A zero factor emits nothing but still moves the position.
    configure(2, 2, 0, 1);
    send_pixel(16'h1234, 1'b1);
    send_pixel(16'hABCD, 1'b0);
    send_pixel(16'h5555, 1'b1);
    drain();

    configure(4, 3, 15, 1);
    send_pixel(16'hAAAA, 1'b1);
    send_pixel(16'h5555, 1'b0);
    drain();

    configure(0, 0, 3, 0);
    send_pixel(16'hFFFF, 1'b1);
    send_pixel(16'h0000, 1'b1);
    drain();

    configure(2047, 2047, 8, 1);
    send_pixel(16'h7FFF, 1'b1);
    send_pixel(16'h8001, 1'b0);
    drain();

    // Shrinking the width mid-image wraps a column that lies past the new edge.
    configure(6, 4, 2, 1);
    send_pixel(16'h0F0F, 1'b1);
    send_pixel(16'hF0F0, 1'b0);
    send_pixel(16'h3C3C, 1'b1);
    send_pixel(16'hC3C3, 1'b1);
    drain();
    configure(2, 3, 2, 1);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b1);
    drain();

    phase_no = 0;
    while (pixels_sent < PIXEL_TARGET) begin
      if (pixels_sent >= PIXEL_TARGET - 40) begin
        calm = 1'b1;
      end
      random_phase(phase_no == 1 ? 16 : $urandom_range(8, 24), phase_no == 1);
      phase_no++;
    end

    $display("summary: %0d pixels over %0d register settings, %0d replicas compared",
             pixels_sent, settings_used, compared);
    $display("summary: factors 0 to 15, sizes 0 to 2047, mid-image resize, long result stall");
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
